[hdl/xkb_pkg.sv]
// Shared types, constants and the base64 alphabet for the XOR key base64 encoder.
package xkb_pkg;

  localparam int KEY_BYTES_DEF = 16;
  localparam int KEY_W         = 64;
  localparam int POS_W         = 4;
  localparam int CHAR_W        = 7;
  localparam int CHARS_MAX     = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_FIRST  = 2'd0,
    REG_KEY_SECOND = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_THIRD  = 2'd2
  } phase_e;

  // One queued job: the characters caused by one input word
  typedef struct packed {
    logic [CHARS_MAX-1:0][CHAR_W-1:0] codes;
    logic [1:0]                        last_idx;
    logic                              last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Map a 6-bit value to its base64 ASCII code
  function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

endpackage

[hdl/xkb_front.sv]
// Front end: key registers, XOR with the cycled key and base64 job building.
module xkb_front import xkb_pkg::*; #(
  parameter int KeyBytes = KEY_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output job_t                 job_o
);

  logic [KEY_W-1:0] key_first_q, key_second_q;
  logic [POS_W-1:0] pos_q, pos_d, pos_use;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       held_q;
  logic [7:0]       key_byte, b;
  logic [2*KEY_W-1:0] key_all;

  assign push_o  = in_valid_i && !q_full_i;
  assign key_all = {key_second_q, key_first_q};

  // Pick the key byte, wrapping a stale position to zero
  always_comb begin
    pos_use  = ({1'b0, pos_q} >= (POS_W+1)'(KeyBytes)) ? '0 : pos_q;
    key_byte = key_all[{pos_use, 3'b000} +: 8];
    b        = data_byte_i ^ key_byte;
  end

  // Build the characters for this word
  always_comb begin
    job_o          = '0;
    job_o.last     = last_byte_i;
    phase_d        = PHASE_SECOND;
    case (phase_q)
      PHASE_SECOND: begin
        job_o.codes[0] = sextet_char({held_q[1:0], b[7:4]});
        if (last_byte_i) begin
          job_o.codes[1] = sextet_char({b[3:0], 2'b00});
          job_o.codes[2] = PAD_CHAR;
          job_o.last_idx = 2'd2;
        end
        phase_d = PHASE_THIRD;
      end
      PHASE_THIRD: begin
        job_o.codes[0] = sextet_char({held_q[3:0], b[7:6]});
        job_o.codes[1] = sextet_char(b[5:0]);
        job_o.last_idx = 2'd1;
        phase_d        = PHASE_FIRST;
      end
      default: begin
        job_o.codes[0] = sextet_char(b[7:2]);
        if (last_byte_i) begin
          job_o.codes[1] = sextet_char({b[1:0], 4'b0000});
          job_o.codes[2] = PAD_CHAR;
          job_o.codes[3] = PAD_CHAR;
          job_o.last_idx = 2'd3;
        end
      end
    endcase
    pos_d = ({1'b0, pos_use} == (POS_W+1)'(KeyBytes - 1)) ? '0 : pos_use + 1'b1;
    if (last_byte_i) begin
      pos_d   = '0;
      phase_d = PHASE_FIRST;
    end
  end

  // Hold key registers and group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= '0;
      key_second_q <= '0;
      pos_q        <= '0;
      phase_q      <= PHASE_FIRST;
      held_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_KEY_FIRST:  key_first_q  <= cfg_data_i;
          REG_KEY_SECOND: key_second_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push_o) begin
        pos_q   <= pos_d;
        phase_q <= phase_d;
        held_q  <= b;
      end
    end
  end

endmodule

[hdl/xkb_queue.sv]
// Short job queue between the front and back ends.
module xkb_queue import xkb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      head_o,
  output q_status_t status_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  job_t            entries_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign status_o.full  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = entries_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[hdl/xkb_back.sv]
// Back end: emits the queued characters one word per cycle through an output register, while out_stall_i is low.
module xkb_back import xkb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              head_i,
  input  q_status_t         status_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              last_char_o
);

  logic              out_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic [1:0]        idx_q;
  logic              advance, emit, at_end;

  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && !status_i.empty;
  assign at_end  = (idx_q == head_i.last_idx);
  assign pop_o   = emit && at_end;

  // Load the output register and step through the job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (advance) begin
      out_valid_q <= emit;
      if (emit) begin
        idx_q <= at_end ? '0 : idx_q + 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= head_i.codes[idx_q];
      last_q <= head_i.last && at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

[hdl/xor_key_base64_encoder.sv]
// Top level of the repeating-key XOR base64 encoder.
// An accepted word is queued as a job; its first character then enters the output register.
// Throughput: one character per cycle from the back end while out_stall_i is low;
// a group of three input words gives four characters.
// The front end takes a word every cycle while the two-entry job queue has room.
// Reset (rst_ni low, asynchronous) clears the key, key position, group phase and queue.
module xor_key_base64_encoder import xkb_pkg::*; #(
  parameter int KeyBytes = KEY_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CHAR_W-1:0]    char_code_o,
  output logic                 last_char_o
);

  job_t      job, head;
  q_status_t q_status;
  logic      push, pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;

  xkb_front #(.KeyBytes(KeyBytes)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_status.full),
    .push_o      (push),
    .job_o       (job)
  );

  xkb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  xkb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

`ifndef SYNTHESIS
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("job popped from an empty queue");

  a_out_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_status.empty))
    else $error("output word appeared without a queued job");
`endif

endmodule

[test/tb.sv]
// Testbench for the repeating-key XOR base64 encoder, with a queued driver and a scoreboard.
`timescale 1ns / 100ps

module tb import xkb_pkg::*; ();

  // Index values that no key register decodes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [CHAR_W-1:0]    PAD_CODE     = 7'd61;
  localparam bit [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } enc_char_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [KEY_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i = '0;
  logic                 last_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CHAR_W-1:0]    char_code_o;
  logic                 last_char_o;

  msg_byte_t byte_q[$];
  enc_char_t char_q[$];
  int        errors = 0;
  bit        steady = 1'b0;

  // Shadow of the encoder state
  logic [KEY_W-1:0] key_lo   = '0;
  logic [KEY_W-1:0] key_hi   = '0;
  logic [POS_W-1:0] key_pos  = '0;
  phase_e           grp_phase = PHASE_FIRST;
  logic [7:0]       held     = '0;

  xor_key_base64_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [CHAR_W-1:0] b64_code(input logic [5:0] v);
    return ALPHABET[504 - int'(v) * 8 +: 7];
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] c, input logic l);
    enc_char_t e;
    e.code = c;
    e.last = l;
    char_q.push_back(e);
  endfunction

  // Predict the characters caused by one accepted message byte
  function automatic void encode_byte(input logic [7:0] raw, input logic fin);
    logic [7:0] kb;
    logic [7:0] b;
    kb = key_pos[3] ? key_hi[int'(key_pos[2:0]) * 8 +: 8]
                    : key_lo[int'(key_pos[2:0]) * 8 +: 8];
    b = raw ^ kb;
    case (grp_phase)
      PHASE_SECOND: begin
        push_char(b64_code({held[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          push_char(b64_code({b[3:0], 2'b00}), 1'b0);
          push_char(PAD_CODE, 1'b1);
        end
        grp_phase = PHASE_THIRD;
      end
      PHASE_THIRD: begin
        push_char(b64_code({held[3:0], b[7:6]}), 1'b0);
        push_char(b64_code(b[5:0]), fin);
        grp_phase = PHASE_FIRST;
      end
      default: begin
        // unused phase code behaves as the first phase
        push_char(b64_code(b[7:2]), 1'b0);
        if (fin) begin
          push_char(b64_code({b[1:0], 4'b0000}), 1'b0);
          push_char(PAD_CODE, 1'b0);
          push_char(PAD_CODE, 1'b1);
        end
        grp_phase = PHASE_SECOND;
      end
    endcase
    held = b;
    key_pos = key_pos + 1'b1;
    if (fin) begin
      key_pos = '0;
      grp_phase = PHASE_FIRST;
    end
  endfunction

  // Drive message words from the pending queue, idling at random unless steady is set
  always @(posedge clk_i or negedge rst_ni) begin : drive
    msg_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        encode_byte(data_byte_i, last_byte_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (byte_q.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
          nxt = byte_q.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= nxt.data;
          last_byte_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check each character word against the oldest prediction, and stall the output at random unless steady is set
  always @(posedge clk_i or negedge rst_ni) begin : watch
    enc_char_t exp_c;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (char_q.size() == 0) begin
          $error("unexpected word: char_code %0d last_char %0b", char_code_o, last_char_o);
          errors++;
        end else begin
          exp_c = char_q.pop_front();
          if (char_code_o !== exp_c.code) begin
            $error("char_code: expected %0d, got %0d", exp_c.code, char_code_o);
            errors++;
          end
          if (last_char_o !== exp_c.last) begin
            $error("last_char: expected %0b, got %0b", exp_c.last, last_char_o);
            errors++;
          end
        end
      end
      out_stall_i <= !steady && ($urandom_range(99) < 15);
    end
  end

  // Hold until every queued word is sent and every character has come back
  task automatic wait_idle();
    while (byte_q.size() > 0 || in_valid_i || char_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_KEY_FIRST) key_lo = val;
    else if (idx == REG_KEY_SECOND) key_hi = val;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_byte(input logic [7:0] d, input logic l);
    msg_byte_t m;
    m.data = d;
    m.last = l;
    byte_q.push_back(m);
  endfunction

  // Queue random messages; leave the final one open when asked
  function automatic void add_messages(input int count, input bit leave_open);
    int len;
    int sent;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 7);
      if (sent + len > count) len = count - sent;
      for (int k = 0; k < len; k++) begin
        add_byte(8'($urandom_range(255)),
                 (k == len - 1) && !(leave_open && sent + len == count));
      end
      sent += len;
    end
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero key after reset: lone byte and a full group
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h7F, 1'b1);
    wait_idle();

    // All-ones key: double and single padding
    write_reg(REG_KEY_FIRST, '1);
    write_reg(REG_KEY_SECOND, '0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    wait_idle();

    // Long message that wraps the key position
    write_reg(REG_KEY_FIRST, rand_key());
    write_reg(REG_KEY_SECOND, '1);
    for (int k = 0; k < 17; k++) add_byte(8'($urandom_range(255)), k == 16);
    wait_idle();

    // Spare indexes must leave the key untouched
    write_reg(REG_SPARE_LO, rand_key());
    write_reg(REG_SPARE_HI, rand_key());
    add_messages(35, 1'b1);
    wait_idle();

    // Key change in the middle of an open message
    write_reg(REG_KEY_SECOND, rand_key());
    steady = 1'b1;
    add_messages(50, $urandom_range(1));
    wait_idle();
    steady = 1'b0;

    write_reg(REG_KEY_FIRST, rand_key());
    write_reg(REG_KEY_SECOND, rand_key());
    add_messages(33, 1'b1);
    wait_idle();

    write_reg(REG_KEY_FIRST, '0);
    write_reg(REG_KEY_SECOND, '0);
    add_messages(28, 1'b0);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Bound the run in case the encoder hangs
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
hdl/xkb_pkg.sv
hdl/xkb_front.sv
hdl/xkb_queue.sv
hdl/xkb_back.sv
hdl/xor_key_base64_encoder.sv
test/tb.sv
